>>> hdl/ed_pkg.sv
package ed_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int COST_W  = $clog2(MAX_LEN + 2);
    localparam int SYM_W   = 8;
    localparam int OP_W    = 2;
    localparam int DIST_W  = 7;

    localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SYM_W-1:0] symbol;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } out_beat_t;

    // one row of the cost table travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SYM_W-1:0]  sym;
        logic [COST_W-1:0] cost_new;
        logic [COST_W-1:0] cost_old;
    } link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

>>> hdl/ed_ram.sv
module ed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ed_cell.sv
module ed_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        clear,
    input  logic                        load,
    input  logic [ed_pkg::SYM_W-1:0]    load_sym,
    input  logic [ed_pkg::COST_W-1:0]   init_cost,
    input  ed_pkg::link_t               link_in,
    output ed_pkg::link_t               link_out
);

    logic                       active_reg, active_next;
    logic [ed_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic [ed_pkg::COST_W-1:0]  cost_reg, cost_next;
    ed_pkg::link_t              out_reg, out_next;

    logic [ed_pkg::COST_W-1:0]  up_cost, left_cost, diag_cost, best;

    always_comb begin
        up_cost   = cost_reg + ed_pkg::COST_W'(1);
        left_cost = link_in.cost_new + ed_pkg::COST_W'(1);
        diag_cost = link_in.cost_old + ed_pkg::COST_W'(link_in.sym != sym_reg);
        best      = (up_cost < left_cost) ? up_cost : left_cost;
        best      = (diag_cost < best) ? diag_cost : best;

        active_next = active_reg;
        sym_next    = sym_reg;
        cost_next   = cost_reg;
        out_next    = link_in;

        if (load) begin
            active_next = 1'b1;
            sym_next    = load_sym;
        end
        if (clear) begin
            active_next = 1'b0;
        end
        if (start) begin
            cost_next = init_cost;
        end
        // inactive cells pass the row through untouched
        if (link_in.valid && active_reg) begin
            cost_next         = best;
            out_next.cost_new = best;
            out_next.cost_old = cost_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_reg.valid <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_reg.valid <= out_next.valid;
        end
        sym_reg           <= sym_next;
        cost_reg          <= cost_next;
        out_reg.last      <= out_next.last;
        out_reg.sym       <= out_next.sym;
        out_reg.cost_new  <= out_next.cost_new;
        out_reg.cost_old  <= out_next.cost_old;
    end

    assign link_out = out_reg;

endmodule

>>> hdl/edit_distance.sv
// Levenshtein edit distance between two byte strings.
// Input channel s_valid/s_ready/s_data carries one beat per operation:
// append a byte to the first string, append a byte to the second string,
// or finish. Finish returns one beat on m_valid/m_ready/m_data holding the
// distance and the overflow flag, then empties both strings.
// Appends are taken one per cycle. Bytes beyond MAX_LEN are dropped and set
// the overflow flag; a finish then reports distance 0 with overflow set.
// The second string sits in a chain of MAX_LEN cells, one column of the cost
// row each. Rows of the first string are read from a RAM and sent down the
// chain as a skewed wavefront, one row per cycle.
// On a finish, m_valid rises after the last row has left the last cell of
// the chain; with an empty first string or after overflow, the result goes
// from the DONE state to the output register without using the chain.
// s_ready stays low from an accepted finish until its result is registered.
// A stalled receiver holds the result beat; appends are still taken then,
// a new finish is also taken, its result waits until the pending beat leaves.
// Reset (aresetn low, synchronous) empties both strings, clears the flag and
// drops any pending result.
module edit_distance (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ed_pkg::in_beat_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ed_pkg::out_beat_t  m_data
);

    ed_pkg::state_t               state_reg, state_next;
    logic [ed_pkg::LEN_W-1:0]     len1_reg, len1_next;
    logic [ed_pkg::LEN_W-1:0]     len2_reg, len2_next;
    logic                         ovf_reg, ovf_next;
    logic [ed_pkg::LEN_W-1:0]     cnt_reg, cnt_next;
    logic                         iss_v_reg, iss_v_next;
    logic                         iss_last_reg, iss_last_next;
    logic [ed_pkg::COST_W-1:0]    iss_row_reg, iss_row_next;
    ed_pkg::out_beat_t            res_reg, res_next;
    logic                         m_valid_reg, m_valid_next;
    ed_pkg::out_beat_t            m_data_reg, m_data_next;

    logic                         s_fire;
    logic                         ram_we;
    logic                         cell_we;
    logic                         start;
    logic                         clear;
    logic [ed_pkg::SYM_W-1:0]     ram_rdata;
    logic [ed_pkg::LEN_W-1:0]     cnt_inc;

    ed_pkg::link_t                link [ed_pkg::MAX_LEN+1];

    assign s_ready = (state_reg == ed_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign cnt_inc = cnt_reg + ed_pkg::LEN_W'(1);

    always_comb begin
        state_next    = state_reg;
        len1_next     = len1_reg;
        len2_next     = len2_reg;
        ovf_next      = ovf_reg;
        cnt_next      = cnt_reg;
        iss_v_next    = 1'b0;
        iss_last_next = 1'b0;
        iss_row_next  = iss_row_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        cell_we       = 1'b0;
        start         = 1'b0;
        clear         = 1'b0;

        case (state_reg)
            ed_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.operation)
                        ed_pkg::OP_FIRST: begin
                            if (len1_reg < ed_pkg::LEN_W'(ed_pkg::MAX_LEN)) begin
                                ram_we    = 1'b1;
                                len1_next = len1_reg + ed_pkg::LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ed_pkg::OP_SECOND: begin
                            if (len2_reg < ed_pkg::LEN_W'(ed_pkg::MAX_LEN)) begin
                                cell_we   = 1'b1;
                                len2_next = len2_reg + ed_pkg::LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ed_pkg::OP_FINISH: begin
                            cnt_next = '0;
                            if (ovf_reg) begin
                                res_next.distance = '0;
                                res_next.overflow = 1'b1;
                                state_next        = ed_pkg::ST_DONE;
                            end else if (len1_reg == '0) begin
                                res_next.distance = ed_pkg::DIST_W'(len2_reg);
                                res_next.overflow = 1'b0;
                                state_next        = ed_pkg::ST_DONE;
                            end else begin
                                start      = 1'b1;
                                state_next = ed_pkg::ST_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ed_pkg::ST_RUN: begin
                iss_v_next    = 1'b1;
                iss_last_next = (cnt_inc == len1_reg);
                iss_row_next  = ed_pkg::COST_W'(cnt_inc);
                cnt_next      = cnt_inc;
                if (cnt_inc == len1_reg) begin
                    state_next = ed_pkg::ST_DRAIN;
                end
            end
            ed_pkg::ST_DRAIN: begin
                if (link[ed_pkg::MAX_LEN].valid && link[ed_pkg::MAX_LEN].last) begin
                    res_next.distance =
                        ed_pkg::DIST_W'(link[ed_pkg::MAX_LEN].cost_new);
                    res_next.overflow = 1'b0;
                    state_next        = ed_pkg::ST_DONE;
                end
            end
            ed_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    len1_next    = '0;
                    len2_next    = '0;
                    ovf_next     = 1'b0;
                    clear        = 1'b1;
                    state_next   = ed_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ed_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ed_pkg::ST_IDLE;
            len1_reg    <= '0;
            len2_reg    <= '0;
            ovf_reg     <= 1'b0;
            iss_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len1_reg    <= len1_next;
            len2_reg    <= len2_next;
            ovf_reg     <= ovf_next;
            iss_v_reg   <= iss_v_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg      <= cnt_next;
        iss_last_reg <= iss_last_next;
        iss_row_reg  <= iss_row_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    ed_ram #(
        .WIDTH (ed_pkg::SYM_W),
        .DEPTH (ed_pkg::MAX_LEN)
    ) u_first_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len1_reg[ed_pkg::ADDR_W-1:0]),
        .wdata (s_data.symbol),
        .raddr (cnt_reg[ed_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // column 0 of the table is the row index itself
    assign link[0] = {iss_v_reg, iss_last_reg, ram_rdata, iss_row_reg,
                      iss_row_reg - ed_pkg::COST_W'(1)};

    for (genvar j = 0; j < ed_pkg::MAX_LEN; j++) begin : g_cell
        ed_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (start),
            .clear     (clear),
            .load      (cell_we && (len2_reg == ed_pkg::LEN_W'(j))),
            .load_sym  (s_data.symbol),
            .init_cost (ed_pkg::COST_W'(j + 1)),
            .link_in   (link[j]),
            .link_out  (link[j+1])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
